/* hw/rtl/bwm_pkg.sv */
// Shared types and constants for the byte window match and range scanner.
// Used by bwm_eval and byte_window_match_range_scan; depends on nothing.
`default_nettype none

package bwm_pkg;

  // Default for the widest window in bytes.
  localparam int unsigned MAX_WINDOW_DEF = 8;

  // Widths fixed by the register map and the data words.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned WIDTH_W = 4;
  localparam int unsigned SKIP_W = 3;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned VALUE_W = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_WINDOW_WIDTH = 3'd1,
    CFG_KEY_OR_LOW   = 3'd2,
    CFG_UPPER_BOUND  = 3'd3,
    CFG_BASE_ADDRESS = 3'd4
  } cfg_index_t;

  // Scan mode.
  typedef enum logic {
    MODE_MATCH = 1'b0,
    MODE_RANGE = 1'b1
  } mode_t;

  // Compare settings handed to the evaluator.
  typedef struct packed {
    mode_t                    mode;
    logic [WIDTH_W-1:0]       window_width;
    logic signed [VALUE_W-1:0] key_or_low;
    logic signed [VALUE_W-1:0] upper_bound;
  } cmp_cfg_t;

  // Evaluator results for the current window.
  typedef struct packed {
    logic               key_equal;
    logic               in_range;
    logic [WIDTH_W-1:0] width_eff;
    logic [VALUE_W-1:0] window_value;
  } eval_t;

endpackage

`default_nettype wire

/* hw/rtl/byte_window_match_range_scan.sv */
// Top level of the sliding window byte scanner: input register, window state,
// hit decision and result register. Depends on bwm_pkg and bwm_eval.
//
// Usage: bytes of a memory region enter on the s_axis channel in address
// order, one word per byte, with s_axis_tlast on the final byte of a region.
// Each word shifts into a window of window_width bytes. In match mode a window
// equal to the low bytes of key_or_low is reported and the next width-1
// positions are skipped; in range mode every window with value v, low <= v <
// high, is reported, with low and high the low bytes of key_or_low and
// upper_bound, all compared as signed 64-bit words. A hit leaves on m_axis as
// one word carrying the window's start address and its bytes. Throughput is
// one byte per cycle while m_axis does not stall. A byte passes the input
// register, then the result register; the window shift, masked compare and
// signed compares between them are combinational. When m_axis stalls, an
// empty input register still takes one more byte; after that s_axis_tready
// falls until the result word is taken. Reset (rst, synchronous) empties
// both registers, clears the window and sets the configuration defaults.
// Configuration writes must be made while the block is idle; the block does
// not enforce this. Writing base_address also restarts the address.
`default_nettype none

module byte_window_match_range_scan #(
  parameter int unsigned MAX_WINDOW = bwm_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Byte stream in.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // region_end
  // Hit words out.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*bwm_pkg::VALUE_W-1:0]     m_axis_tdata    // [63:0] hit_address,
                                                            // [127:64] hit_bytes
);
  import bwm_pkg::*;

  localparam int unsigned WIN_BITS = 8 * MAX_WINDOW;
  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_WINDOW);

  // Configuration registers.
  mode_t               mode;
  logic [WIDTH_W-1:0]  window_width;
  logic [VALUE_W-1:0]  key_or_low;
  logic [VALUE_W-1:0]  upper_bound;
  logic [ADDR_W-1:0]   base_address;

  // Input register.
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;

  // Window state.
  logic [WIN_BITS-1:0] window_shift;
  logic [FILL_W-1:0]   fill_count;
  logic [SKIP_W-1:0]   skip_count;
  logic [ADDR_W-1:0]   byte_address;

  // Result register.
  logic                out_valid;
  logic [ADDR_W-1:0]   hit_address;
  logic [VALUE_W-1:0]  hit_bytes;

  logic                advance;
  logic [WIN_BITS-1:0] window_shift_next;
  logic [FILL_W-1:0]   fill_count_next;
  logic [SKIP_W-1:0]   skip_count_next;
  logic                tested;
  logic                hit;
  cmp_cfg_t            cmp_cfg;
  eval_t               eval;

  // Handshake: the input register moves on when the result slot is free.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {hit_bytes, hit_address};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_MATCH;
      window_width <= WIDTH_W'(1);
      key_or_low   <= '0;
      upper_bound  <= '0;
      base_address <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:         mode         <= mode_t'(cfg_data[0]);
        CFG_WINDOW_WIDTH: window_width <= cfg_data[WIDTH_W-1:0];
        CFG_KEY_OR_LOW:   key_or_low   <= cfg_data;
        CFG_UPPER_BOUND:  upper_bound  <= cfg_data;
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Shift in the new byte and count the bytes held.
  always_comb begin
    window_shift_next = {in_byte, window_shift[WIN_BITS-1:8]};
    fill_count_next   = (fill_count < FILL_MAX) ? fill_count + FILL_W'(1) : fill_count;
  end

  assign cmp_cfg = '{mode:         mode,
                     window_width: window_width,
                     key_or_low:   key_or_low,
                     upper_bound:  upper_bound};

  bwm_eval #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_eval (
    .cfg          (cmp_cfg),
    .window_shift (window_shift_next),
    .result       (eval)
  );

  // Hit decision; matches do not overlap, so a hit arms the skip counter.
  always_comb begin
    tested          = (WIDTH_W'(fill_count_next) >= eval.width_eff);
    hit             = 1'b0;
    skip_count_next = skip_count;
    if (tested) begin
      if (mode == MODE_MATCH) begin
        if (skip_count != '0) begin
          skip_count_next = skip_count - SKIP_W'(1);
        end else if (eval.key_equal) begin
          hit             = 1'b1;
          skip_count_next = SKIP_W'(eval.width_eff - WIDTH_W'(1));
        end
      end else begin
        hit = eval.in_range;
      end
    end
  end

  // Window state; the region end clears it and restarts the address.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_shift <= '0;
      fill_count   <= '0;
      skip_count   <= '0;
      byte_address <= '0;
    end else begin
      if (advance) begin
        if (in_last) begin
          window_shift <= '0;
          fill_count   <= '0;
          skip_count   <= '0;
          byte_address <= base_address;
        end else begin
          window_shift <= window_shift_next;
          fill_count   <= fill_count_next;
          skip_count   <= skip_count_next;
          byte_address <= byte_address + ADDR_W'(1);
        end
      end
      if (cfg_wr_en && cfg_index == CFG_BASE_ADDRESS) begin
        byte_address <= cfg_data;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      hit_address <= byte_address - ADDR_W'(eval.width_eff - WIDTH_W'(1));
      hit_bytes   <= eval.window_value;
    end
  end

`ifndef SYNTHESIS
  // The fill count saturates at the widest window.
  assert property (@(posedge clk) disable iff (rst) fill_count <= FILL_MAX)
    else $error("fill count above the widest window");

  // A region end empties the window on the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> fill_count == '0 && skip_count == '0)
    else $error("window not cleared after region end");

  // A byte held in the input register is never dropped while stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled input byte lost");

  // A waiting result word is not overwritten by a new hit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !advance)
    else $error("result word overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bwm_eval.sv */
// Window evaluator: picks the active window bytes out of the shift line and
// compares them against the key or the range bounds. Depends on bwm_pkg.
`default_nettype none

module bwm_eval #(
  parameter int unsigned MAX_WINDOW = bwm_pkg::MAX_WINDOW_DEF
) (
  input  bwm_pkg::cmp_cfg_t       cfg,
  input  logic [8*MAX_WINDOW-1:0] window_shift,
  output bwm_pkg::eval_t          result
);
  import bwm_pkg::*;

  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WINDOW);

  logic [WIDTH_W-1:0] width_eff;
  logic [6:0]         drop_bits;
  logic [6:0]         keep_bits;
  logic [VALUE_W-1:0] shift_ext;
  logic [VALUE_W-1:0] window_value;
  logic [VALUE_W-1:0] byte_mask;
  logic [VALUE_W-1:0] low_cut;
  logic [VALUE_W-1:0] high_cut;

  // Width zero acts as one byte, widths past the maximum saturate.
  always_comb begin
    if (cfg.window_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (cfg.window_width > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = cfg.window_width;
    end
  end

  // The newest byte sits on top, so the window is the top width_eff bytes.
  // A shift by the full 64 bits yields zero, which makes the all-ones mask.
  always_comb begin
    drop_bits    = 7'(8 * (int'(MAX_WINDOW) - int'(width_eff)));
    keep_bits    = 7'(8 * int'(width_eff));
    shift_ext    = VALUE_W'(window_shift);
    window_value = shift_ext >> drop_bits;
    byte_mask    = (VALUE_W'(1) << keep_bits) - VALUE_W'(1);
    low_cut      = cfg.key_or_low & byte_mask;
    high_cut     = cfg.upper_bound & byte_mask;
  end

  // Exact match and signed half-open range test.
  always_comb begin
    result.width_eff    = width_eff;
    result.window_value = window_value;
    result.key_equal    = (window_value == low_cut);
    result.in_range     = ($signed(window_value) >= $signed(low_cut)) &&
                          ($signed(window_value) < $signed(high_cut));
  end

endmodule

`default_nettype wire
